@@ rtl/assert_macros.svh @@
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cfale_pkg.sv @@
// types, constants and character functions of the can log line encoder
`default_nettype none
package cfale_pkg;

   localparam int LINE_BYTES = 41;
   localparam int IDX_W      = 6;
   localparam int TS_W       = 32;
   localparam int ID_W       = 29;
   localparam int DATA_W     = 64;
   localparam int CNT_W      = 8;
   localparam int DIGITS     = 10;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int ID_NIBS    = 8;
   localparam int DATA_NIBS  = DATA_W / 4;
   localparam int STEP_W     = $clog2(TS_W);
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd128;
   localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;

   localparam logic [IDX_W-1:0] POS_OPEN  = 6'd0;
   localparam logic [IDX_W-1:0] POS_TS    = 6'd1;
   localparam logic [IDX_W-1:0] POS_CLOSE = 6'd11;
   localparam logic [IDX_W-1:0] POS_SP1   = 6'd12;
   localparam logic [IDX_W-1:0] POS_X     = 6'd13;
   localparam logic [IDX_W-1:0] POS_SP2   = 6'd14;
   localparam logic [IDX_W-1:0] POS_ID    = 6'd15;
   localparam logic [IDX_W-1:0] POS_HASH  = 6'd23;
   localparam logic [IDX_W-1:0] POS_DATA  = 6'd24;
   localparam logic [IDX_W-1:0] POS_NL    = IDX_W'(LINE_BYTES - 1);

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ALPHA = 8'h37;
   localparam logic [7:0] CH_NONE  = 8'h00;

   typedef struct packed {
      logic              err;
      logic              tgt;
      logic              swapped;
      logic [TS_W-1:0]   ts;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } job_type;

   typedef struct packed {
      logic              err;
      logic              tgt;
      logic              swapped;
      logic [BCD_W-1:0]  digits;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } line_type;

   typedef enum logic [1:0] {
      CV_IDLE,
      CV_RUN,
      CV_HOLD
   } conv_state_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return {4'b0000, nib} + ((nib < 4'd10) ? CH_ZERO : CH_ALPHA);
   endfunction

   function automatic logic [7:0] line_char(input logic [IDX_W-1:0] idx,
                                            input line_type ln);
      logic [IDX_W-1:0] off;
      logic [3:0]       nib;
      logic [7:0]       ch;
      off = '0;
      nib = '0;
      ch  = CH_NL;
      if (idx == POS_OPEN) begin
         ch = CH_OPEN;
      end else if (idx < POS_CLOSE) begin
         off = idx - POS_TS;
         nib = 4'(ln.digits >> {(IDX_W'(DIGITS - 1) - off), 2'b00});
         ch  = CH_ZERO + {4'b0000, nib};
      end else if (idx == POS_CLOSE) begin
         ch = CH_CLOSE;
      end else if (idx == POS_SP1 || idx == POS_SP2) begin
         ch = CH_SPACE;
      end else if (idx == POS_X) begin
         ch = CH_X;
      end else if (idx < POS_HASH) begin
         off = idx - POS_ID;
         nib = 4'({{(4 * ID_NIBS - ID_W){1'b0}}, ln.id} >>
                  {(IDX_W'(ID_NIBS - 1) - off), 2'b00});
         ch  = hex_char(nib);
      end else if (idx == POS_HASH) begin
         ch = CH_HASH;
      end else if (idx < POS_NL) begin
         off = idx - POS_DATA;
         nib = 4'(ln.data >> {(IDX_W'(DATA_NIBS - 1) - off), 2'b00});
         ch  = hex_char(nib);
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ rtl/cfale_if.sv @@
// request and response channel interfaces of the can log line encoder
`default_nettype none
interface cfale_req_if import cfale_pkg::*;;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [TS_W-1:0]   timestamp_ms;
   logic [ID_W-1:0]   frame_id;
   logic [DATA_W-1:0] frame_data;

   modport source (output valid, kind, timestamp_ms, frame_id, frame_data,
                   input ready);
   modport sink (input valid, kind, timestamp_ms, frame_id, frame_data,
                 output ready);
endinterface

interface cfale_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   logic       target_buffer;
   logic       buffer_ready;
   logic       overflow_error;

   modport source (output valid, char_code, last_char, target_buffer, buffer_ready,
                   overflow_error, input ready);
   modport sink (input valid, char_code, last_char, target_buffer, buffer_ready,
                 overflow_error, output ready);
endinterface
`default_nettype wire

@@ rtl/cfale_front.sv @@
// front end: accepts items, tracks the ping-pong buffers, queues line jobs
`default_nettype none
`include "assert_macros.svh"
module cfale_front import cfale_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   cfale_req_if.sink              req_chan,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   input  wire logic              fifo_full,
   output logic                   push,
   output job_type                push_job
);

   logic [CNT_W-1:0] limit_ff, limit_in;
   logic             active_ff, active_in;
   logic [CNT_W-1:0] fill0_ff, fill0_in;
   logic [CNT_W-1:0] fill1_ff, fill1_in;
   logic             ready_pending_ff, ready_pending_in;
   logic             halted_ff, halted_in;

   logic             accept;
   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] cur;
   logic [CNT_W-1:0] inc;
   logic             both_full;

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      lim       = (limit_ff == '0) ? CNT_W'(1) : limit_ff;
      cur       = active_ff ? fill1_ff : fill0_ff;
      inc       = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);
      both_full = (fill0_ff >= lim) && (fill1_ff >= lim);

      limit_in         = csr_we ? csr_wdata : limit_ff;
      active_in        = active_ff;
      fill0_in         = fill0_ff;
      fill1_in         = fill1_ff;
      ready_pending_in = ready_pending_ff;
      halted_in        = halted_ff;

      push             = 1'b0;
      push_job.err     = 1'b0;
      push_job.tgt     = active_ff;
      push_job.swapped = 1'b0;
      push_job.ts      = req_chan.timestamp_ms;
      push_job.id      = req_chan.frame_id;
      push_job.data    = req_chan.frame_data;

      if (accept) begin
         if (req_chan.kind) begin
            if (!halted_ff) begin
               if (active_ff) begin
                  fill0_in = '0;
               end else begin
                  fill1_in = '0;
               end
               ready_pending_in = 1'b0;
            end
         end else if (halted_ff || both_full) begin
            halted_in    = 1'b1;
            push         = 1'b1;
            push_job.err = 1'b1;
         end else begin
            push = 1'b1;
            if (active_ff) begin
               fill1_in = inc;
            end else begin
               fill0_in = inc;
            end
            if (inc >= lim) begin
               ready_pending_in = 1'b1;
               active_in        = !active_ff;
               push_job.swapped = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff         <= LIMIT_RESET;
         active_ff        <= 1'b0;
         fill0_ff         <= '0;
         fill1_ff         <= '0;
         ready_pending_ff <= 1'b0;
         halted_ff        <= 1'b0;
      end else begin
         limit_ff         <= limit_in;
         active_ff        <= active_in;
         fill0_ff         <= fill0_in;
         fill1_ff         <= fill1_in;
         ready_pending_ff <= ready_pending_in;
         halted_ff        <= halted_in;
      end
   end

   `ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff, "halt cleared")
   `ASSERT_NEXT(a_swap_pending, clock, reset, push && push_job.swapped,
                ready_pending_ff && (active_ff != $past(active_ff)), "swap lost")
   `ASSERT_NEXT(a_drain_clear, clock, reset,
                accept && req_chan.kind && !halted_ff && !active_ff,
                fill1_ff == '0 && !ready_pending_ff, "drain missed")

endmodule
`default_nettype wire

@@ rtl/cfale_fifo.sv @@
// two-entry job queue between the front end and the converter
`default_nettype none
module cfale_fifo import cfale_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   input  wire logic pop,
   output job_type   head,
   output logic      full,
   output logic      empty
);

   job_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full      = (count_ff == FCNT_W'(FIFO_DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FCNT_W'(do_push) - FCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/cfale_conv.sv @@
// timestamp converter: binary to ten decimal digits, one bit per cycle
`default_nettype none
module cfale_conv import cfale_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic fifo_empty,
   input  job_type   fifo_head,
   output logic      pop,
   output logic      line_valid,
   output line_type  line,
   input  wire logic line_take
);

   conv_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [TS_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BCD_W-1:0]   adj;

   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? bcd_ff[4*k +: 4] + 4'd3
                                                    : bcd_ff[4*k +: 4];
      end
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      step_in    = step_ff;
      pop        = 1'b0;
      line_valid = 1'b0;
      case (state_ff)
         CV_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               job_in   = fifo_head;
               bin_in   = fifo_head.ts;
               bcd_in   = '0;
               step_in  = '0;
               state_in = fifo_head.err ? CV_HOLD : CV_RUN;
            end
         end
         CV_RUN: begin
            bcd_in  = {adj[BCD_W-2:0], bin_ff[TS_W-1]};
            bin_in  = {bin_ff[TS_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TS_W - 1)) begin
               state_in = CV_HOLD;
            end
         end
         CV_HOLD: begin
            line_valid = 1'b1;
            if (line_take) begin
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   assign line.err     = job_ff.err;
   assign line.tgt     = job_ff.tgt;
   assign line.swapped = job_ff.swapped;
   assign line.digits  = bcd_ff;
   assign line.id      = job_ff.id;
   assign line.data    = job_ff.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
   end

endmodule
`default_nettype wire

@@ rtl/cfale_back.sv @@
// back end: streams one log line out a character per transfer
`default_nettype none
`include "assert_macros.svh"
module cfale_back import cfale_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic line_valid,
   input  line_type  line,
   output logic      line_take,
   cfale_rsp_if.source rsp_chan
);

   line_type         line_ff, line_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_tgt_ff, rsp_tgt_in;
   logic             rsp_rdy_ff, rsp_rdy_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             adv;
   logic             is_last;

   always_comb begin
      adv       = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
      is_last   = line_ff.err || (idx_ff == POS_NL);
      line_take = line_valid && (!busy_ff || (adv && is_last));

      line_in      = line_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_rdy_in   = rsp_rdy_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = line_ff.err ? CH_NONE : line_char(idx_ff, line_ff);
         rsp_last_in  = is_last;
         rsp_tgt_in   = !line_ff.err && line_ff.tgt;
         rsp_rdy_in   = !line_ff.err && is_last && line_ff.swapped;
         rsp_ovf_in   = line_ff.err;
         idx_in       = idx_ff + IDX_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (line_take) begin
         line_in = line;
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.char_code      = rsp_char_ff;
   assign rsp_chan.last_char      = rsp_last_ff;
   assign rsp_chan.target_buffer  = rsp_tgt_ff;
   assign rsp_chan.buffer_ready   = rsp_rdy_ff;
   assign rsp_chan.overflow_error = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_tgt_ff  <= rsp_tgt_in;
      rsp_rdy_ff  <= rsp_rdy_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   `ASSERT_IMPL(a_idx_range, clock, reset, busy_ff, idx_ff <= POS_NL, "index past line end")
   `ASSERT_NEXT(a_newline_last, clock, reset, adv && !line_ff.err && idx_ff == POS_NL,
                rsp_char_ff == CH_NL && rsp_last_ff, "newline not last")
   `ASSERT_IMPL(a_error_shape, clock, reset, rsp_valid_ff && rsp_ovf_ff,
                rsp_last_ff && rsp_char_ff == CH_NONE && !rsp_rdy_ff, "bad error transfer")

endmodule
`default_nettype wire

@@ rtl/can_frame_ascii_log_encoder.sv @@
// throughput: one character per cycle while the response channel is ready
// the binary-to-decimal converter overlaps the emitter
// drain items end at the front, errors make one transfer at the back
// synchronous reset clears buffer state, halt and queues; limit returns to 128
`default_nettype none
module can_frame_ascii_log_encoder import cfale_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   cfale_req_if.sink             req_chan,
   cfale_rsp_if.source           rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [CNT_W-1:0] csr_wdata
);

   logic     push;
   job_type  push_job;
   logic     fifo_full;
   logic     fifo_empty;
   job_type  fifo_head;
   logic     pop;
   logic     line_valid;
   line_type line;
   logic     line_take;

   cfale_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fifo_full (fifo_full),
      .push      (push),
      .push_job  (push_job)
   );

   cfale_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (fifo_head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   cfale_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_head  (fifo_head),
      .pop        (pop),
      .line_valid (line_valid),
      .line       (line),
      .line_take  (line_take)
   );

   cfale_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_valid (line_valid),
      .line       (line),
      .line_take  (line_take),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
